[sv/multi_frame_request_validator_assert.svh]
// ----------------------------------------------------------------------------
// Multi-frame request validator assertion macros
// Shared wrappers for the concurrent checks on the validator's ports.
// ----------------------------------------------------------------------------
`ifndef MULTI_FRAME_REQUEST_VALIDATOR_ASSERT_SVH
`define MULTI_FRAME_REQUEST_VALIDATOR_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define MFRV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mfrv check failed");

// Next-cycle implication, live through reset.
`define MFRV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mfrv check failed");

`endif

[sv/mfrv_pkg.sv]
// ----------------------------------------------------------------------------
// Multi-frame request validator package
// Field widths, header layout constants and the input item type.
// ----------------------------------------------------------------------------
package mfrv_pkg;

  localparam int BYTE_W       = 8;
  localparam int ID_W         = 16;
  localparam int COUNT_W      = 16;
  localparam int HEADER_W     = 32;
  // Sub-frame positions are kept modulo 4096.
  localparam int POS_W        = 12;
  localparam int HEADER_BYTES = 4;

  // One input item as it sits in the input register.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_item_t;

endpackage

[sv/multi_frame_request_validator.sv]
// A frame's last byte yields its result item via the input register and the result register.
// Throughput: one byte item per cycle; the sub-frame chain tracker between the
// input register and the result register does one byte's update each cycle.
// A result stalled at the output holds back only a following last byte.
// Reset (rst, synchronous): clears frame state, the register and both stages.
// ----------------------------------------------------------------------------
// Multi-frame request validator
// Checks frame ID, sub-frame count and sub-frame lengths against frame size.
// ----------------------------------------------------------------------------
module multi_frame_request_validator #(
  parameter int MAX_FRAME_BYTES = 1024,
  parameter int LEN_W           = 11
) (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration write channel.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mfrv_pkg::ID_W-1:0]    expected_frame_id,
  // Byte input channel.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mfrv_pkg::BYTE_W-1:0]  data_byte,
  input  logic                         last_byte,
  // Verdict output channel.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         frame_valid,
  output logic [mfrv_pkg::COUNT_W-1:0] payload_count,
  output logic [LEN_W-1:0]             frame_length
);

  logic [mfrv_pkg::ID_W-1:0]    frame_id_reg;
  mfrv_pkg::in_item_t           in_item;
  mfrv_pkg::in_item_t           item;
  logic                         item_valid;
  logic                         advance;
  logic                         fire;
  logic                         res_valid;
  logic                         res_frame_valid;
  logic [mfrv_pkg::COUNT_W-1:0] res_payload_count;
  logic [LEN_W-1:0]             res_frame_length;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_id_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      frame_id_reg <= expected_frame_id;
    end
  end

  assign in_item.data_byte = data_byte;
  assign in_item.last_byte = last_byte;

  // A held item moves on unless it would produce a result into a full output.
  assign advance = !(item.last_byte && out_valid && !out_ready);
  assign fire    = item_valid && advance;

  mfrv_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  mfrv_frame_track #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .LEN_W           (LEN_W)
  ) u_frame_track (
    .clk               (clk),
    .rst               (rst),
    .fire              (fire),
    .item              (item),
    .expected_frame_id (frame_id_reg),
    .res_valid         (res_valid),
    .res_frame_valid   (res_frame_valid),
    .res_payload_count (res_payload_count),
    .res_frame_length  (res_frame_length)
  );

  mfrv_out_stage #(
    .LEN_W (LEN_W)
  ) u_out_stage (
    .clk               (clk),
    .rst               (rst),
    .res_valid         (res_valid),
    .res_frame_valid   (res_frame_valid),
    .res_payload_count (res_payload_count),
    .res_frame_length  (res_frame_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .frame_valid       (frame_valid),
    .payload_count     (payload_count),
    .frame_length      (frame_length)
  );

endmodule

[sv/mfrv_in_stage.sv]
// ----------------------------------------------------------------------------
// Input stage
// Registers one accepted byte item and holds it until the tracker takes it.
// ----------------------------------------------------------------------------
module mfrv_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mfrv_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              item_valid,
  output mfrv_pkg::in_item_t item
);

  // The register can take a new item when empty or when its item moves on.
  assign in_ready = !item_valid || advance;

  // Valid flag of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  // Payload of the input register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

[sv/mfrv_frame_track.sv]
// ----------------------------------------------------------------------------
// Frame tracker
// Follows the header and sub-frame chain byte by byte and forms the verdict
// on the last byte of a frame.
// ----------------------------------------------------------------------------
module mfrv_frame_track #(
  parameter int MAX_FRAME_BYTES = 1024,
  parameter int LEN_W           = 11
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fire,
  input  mfrv_pkg::in_item_t              item,
  input  logic [mfrv_pkg::ID_W-1:0]       expected_frame_id,
  output logic                            res_valid,
  output logic                            res_frame_valid,
  output logic [mfrv_pkg::COUNT_W-1:0]    res_payload_count,
  output logic [LEN_W-1:0]                res_frame_length
);

  localparam int CMP_W = (LEN_W > mfrv_pkg::POS_W) ? LEN_W : mfrv_pkg::POS_W;

  // Frame state.
  logic [LEN_W-1:0]                 byte_position;
  logic [mfrv_pkg::HEADER_W-1:0]    header_bytes;
  logic [mfrv_pkg::POS_W-1:0]       next_length_position;
  logic [mfrv_pkg::COUNT_W-1:0]     subframe_index;
  logic [mfrv_pkg::POS_W-1:0]       expected_length;
  logic                             expected_known;
  logic                             length_overflow;

  logic [LEN_W-1:0]                 byte_position_next;
  logic [mfrv_pkg::HEADER_W-1:0]    header_bytes_next;
  logic [mfrv_pkg::POS_W-1:0]       next_length_position_next;
  logic [mfrv_pkg::COUNT_W-1:0]     subframe_index_next;
  logic [mfrv_pkg::POS_W-1:0]       expected_length_next;
  logic                             expected_known_next;
  logic                             length_overflow_next;

  logic [mfrv_pkg::COUNT_W-1:0]     count_old;
  logic [mfrv_pkg::COUNT_W-1:0]     count_new;
  logic [CMP_W-1:0]                 pos_ext;
  logic [CMP_W:0]                   end_full;
  logic                             length_hit;
  logic [CMP_W-1:0]                 len_ext;
  logic                             id_match;
  logic                             verdict;

  assign count_old  = header_bytes[mfrv_pkg::HEADER_W-1 -: mfrv_pkg::COUNT_W];
  assign pos_ext    = CMP_W'(byte_position);
  assign end_full   = (CMP_W+1)'(pos_ext) + (CMP_W+1)'(item.data_byte) + (CMP_W+1)'(1);
  assign length_hit = (pos_ext == CMP_W'(next_length_position)) &&
                      (subframe_index < count_old);

  // Update of the frame state for the byte in hand.
  always_comb begin
    byte_position_next        = byte_position;
    header_bytes_next         = header_bytes;
    next_length_position_next = next_length_position;
    subframe_index_next       = subframe_index;
    expected_length_next      = expected_length;
    expected_known_next       = expected_known;
    length_overflow_next      = length_overflow;
    if (byte_position < LEN_W'(MAX_FRAME_BYTES)) begin
      if (byte_position < LEN_W'(mfrv_pkg::HEADER_BYTES)) begin
        case (byte_position[1:0])
          2'd0:    header_bytes_next[7:0]   = item.data_byte;
          2'd1:    header_bytes_next[15:8]  = item.data_byte;
          2'd2:    header_bytes_next[23:16] = item.data_byte;
          default: header_bytes_next[31:24] = item.data_byte;
        endcase
      end else if (length_hit) begin
        // A length byte: the next one sits just past this sub-frame's data.
        if (subframe_index == count_old - mfrv_pkg::COUNT_W'(1)) begin
          expected_length_next = end_full[mfrv_pkg::POS_W-1:0];
          expected_known_next  = 1'b1;
        end
        next_length_position_next = end_full[mfrv_pkg::POS_W-1:0];
        subframe_index_next       = subframe_index + mfrv_pkg::COUNT_W'(1);
      end
      byte_position_next = byte_position + LEN_W'(1);
    end else begin
      length_overflow_next = 1'b1;
    end
  end

  // Verdict from the state as it stands after this byte.
  assign count_new = header_bytes_next[mfrv_pkg::HEADER_W-1 -: mfrv_pkg::COUNT_W];
  assign len_ext   = CMP_W'(byte_position_next);
  assign id_match  = (header_bytes_next[mfrv_pkg::ID_W-1:0] == expected_frame_id);

  always_comb begin
    verdict = 1'b0;
    if (!length_overflow_next && id_match &&
        (byte_position_next >= LEN_W'(mfrv_pkg::HEADER_BYTES))) begin
      if (count_new == '0) begin
        verdict = (byte_position_next == LEN_W'(mfrv_pkg::HEADER_BYTES));
      end else begin
        verdict = expected_known_next && (len_ext == CMP_W'(expected_length_next));
      end
    end
  end

  assign res_valid         = fire && item.last_byte;
  assign res_frame_valid   = verdict;
  assign res_payload_count = count_new;
  assign res_frame_length  = byte_position_next;

  // Frame state registers; reset or the last byte of a frame clears them.
  always_ff @(posedge clk) begin
    if (rst || (fire && item.last_byte)) begin
      byte_position        <= '0;
      header_bytes         <= '0;
      next_length_position <= mfrv_pkg::POS_W'(mfrv_pkg::HEADER_BYTES);
      subframe_index       <= '0;
      expected_length      <= '0;
      expected_known       <= 1'b0;
      length_overflow      <= 1'b0;
    end else if (fire) begin
      byte_position        <= byte_position_next;
      header_bytes         <= header_bytes_next;
      next_length_position <= next_length_position_next;
      subframe_index       <= subframe_index_next;
      expected_length      <= expected_length_next;
      expected_known       <= expected_known_next;
      length_overflow      <= length_overflow_next;
    end
  end

endmodule

[sv/mfrv_out_stage.sv]
// ----------------------------------------------------------------------------
// Output stage
// Result register that holds one verdict item until the sink takes it.
// ----------------------------------------------------------------------------
module mfrv_out_stage #(
  parameter int LEN_W = 11
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         res_valid,
  input  logic                         res_frame_valid,
  input  logic [mfrv_pkg::COUNT_W-1:0] res_payload_count,
  input  logic [LEN_W-1:0]             res_frame_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         frame_valid,
  output logic [mfrv_pkg::COUNT_W-1:0] payload_count,
  output logic [LEN_W-1:0]             frame_length
);

  // Valid flag: set by a new result, cleared when the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (res_valid) begin
      frame_valid   <= res_frame_valid;
      payload_count <= res_payload_count;
      frame_length  <= res_frame_length;
    end
  end

endmodule

[sv/mfrv_checker.sv]
// ----------------------------------------------------------------------------
// Validator port checker
// Watches the validator's ports for reset, output hold and verdict consistency.
// ----------------------------------------------------------------------------
`include "multi_frame_request_validator_assert.svh"

module mfrv_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         frame_valid,
  input logic [mfrv_pkg::COUNT_W-1:0] payload_count,
  input logic [15:0]                  frame_length
);

  // Reset leaves no result item pending.
  `MFRV_ASSERT_NXT(a_reset_empty, rst, !out_valid)

  // A stalled result item keeps its verdict and count.
  `MFRV_ASSERT_NXT(a_stall_hold, out_valid && !out_ready && !rst,
    out_valid && $stable(frame_valid) && $stable(payload_count))

  // A valid frame with no sub-frames is exactly the header long.
  `MFRV_ASSERT_IMP(a_empty_len, out_valid && frame_valid && (payload_count == '0),
    frame_length == 16'd4)

  // A valid frame with sub-frames carries at least one length byte.
  `MFRV_ASSERT_IMP(a_sub_len, out_valid && frame_valid && (payload_count != '0),
    frame_length >= 16'd5)

endmodule

bind multi_frame_request_validator mfrv_checker u_mfrv_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .frame_valid   (frame_valid),
  .payload_count (payload_count),
  .frame_length  (16'(frame_length))
);
